// ===== src/kpu_pkg.sv =====
// Package for the 3-axis Kalman position update unit.
// Holds payload and lane control types, register indexes and reset values.
// No dependencies.
package kpu_pkg;

  localparam int AXES              = 3;
  localparam int VAR_FRAC_BITS_DEF = 24;
  localparam int CFG_IDX_W         = 3;

  localparam logic [31:0] RST_PNOISE   = 32'd16777;
  localparam logic [31:0] RST_MNOISE   = 32'd1677722;
  localparam logic [31:0] RST_INIT_VAR = 32'd1678;

  localparam logic [CFG_IDX_W-1:0] REG_PNOISE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PNOISE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PNOISE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MNOISE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MNOISE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MNOISE_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR = 3'd6;

  localparam logic CMD_REINIT = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] prior_x;
    logic signed [31:0] prior_y;
    logic signed [31:0] prior_z;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] meas_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_z;
    logic        [31:0] var_x;
    logic        [31:0] var_y;
    logic        [31:0] var_z;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic reinit;
    logic take;
  } lane_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_sts_t;

endpackage

// ===== src/kpu_lane.sv =====
// One scalar Kalman lane: variance state, iterative gain divider and a
// shared multiplier for the state and estimate corrections.
// Depends on kpu_pkg.
module kpu_lane import kpu_pkg::*; #(
  parameter int VAR_FRAC_BITS = VAR_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lane_ctl_t          ctl,
  input  logic        [31:0] pnoise,
  input  logic        [31:0] mnoise,
  input  logic        [31:0] init_var,
  input  logic signed [31:0] prior,
  input  logic signed [31:0] meas,
  output lane_sts_t          sts,
  output logic signed [31:0] est,
  output logic        [31:0] variance
);

  localparam int KW  = VAR_FRAC_BITS + 1;
  localparam int OBW = 34;
  localparam int PW  = KW + 1 + OBW;
  localparam int CW  = $clog2(VAR_FRAC_BITS);
  localparam logic [PW-1:0] HALF = PW'(1) << (VAR_FRAC_BITS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MULP = 3'd3;
  localparam logic [2:0] S_MULE = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [31:0]             var_r, var_nxt;
  logic [31:0]             p1_r;
  logic signed [OBW-1:0]   e_r;
  logic signed [31:0]      prior_r;
  logic [32:0]             den_r;
  logic [32:0]             rem_r;
  logic [KW-1:0]           q_r;
  logic                    nz_r;
  logic [CW-1:0]           cnt_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [31:0]      est_r;

  logic [32:0]             p_sum;
  logic [31:0]             p1_nxt;
  logic [32:0]             den_nxt;
  logic [33:0]             shl;
  logic [33:0]             diff;
  logic                    ge;
  logic [KW-1:0]           k;
  logic signed [OBW-1:0]   mul_b;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    rsum;
  logic signed [PW-1:0]    rnd;
  logic [31:0]             kp;
  logic signed [PW-1:0]    est_wide;
  logic                    ov_hi;
  logic                    ov_lo;
  logic signed [31:0]      est_sat;

  assign p_sum   = {1'b0, var_r} + {1'b0, pnoise};
  assign p1_nxt  = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
  assign den_nxt = {1'b0, p1_r} + {1'b0, mnoise};

  assign shl  = {rem_r, 1'b0};
  assign ge   = shl >= {1'b0, den_r};
  assign diff = shl - {1'b0, den_r};

  // numerator zero gives zero gain, also covering a zero denominator
  assign k     = nz_r ? q_r : '0;
  assign mul_b = (state_r == S_MULP) ? $signed({2'b00, p1_r}) : e_r;
  assign prod  = $signed({1'b0, k}) * mul_b;

  assign rsum = prod_r + $signed(HALF);
  assign rnd  = rsum >>> VAR_FRAC_BITS;
  assign kp   = (rnd > $signed({{(PW-32){1'b0}}, p1_r})) ? p1_r : rnd[31:0];

  assign est_wide = $signed({{(PW-32){prior_r[31]}}, prior_r}) + rnd;
  assign ov_hi    = !est_wide[PW-1] && (|est_wide[PW-2:31]);
  assign ov_lo    = est_wide[PW-1] && !(&est_wide[PW-2:31]);
  assign est_sat  = ov_hi ? 32'sh7FFF_FFFF :
                    ov_lo ? -32'sh8000_0000 : est_wide[31:0];

  always_comb begin
    state_nxt = state_r;
    var_nxt   = var_r;
    case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          if (ctl.reinit) begin
            var_nxt   = init_var;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_MULP;
        end
      end
      S_MULP: state_nxt = S_MULE;
      S_MULE: begin
        var_nxt   = p1_r - kp;
        state_nxt = S_FIN;
      end
      S_FIN:  state_nxt = S_DONE;
      S_DONE: begin
        if (ctl.take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      var_r   <= RST_INIT_VAR;
    end else begin
      state_r <= state_nxt;
      var_r   <= var_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        p1_r    <= p1_nxt;
        prior_r <= prior;
        est_r   <= prior;
        e_r     <= {{2{meas[31]}}, meas} - {{2{prior[31]}}, prior};
      end
      S_PREP: begin
        den_r <= den_nxt;
        nz_r  <= p1_r != '0;
        cnt_r <= CW'(VAR_FRAC_BITS - 1);
        // integer gain bit is set only when p1 equals the denominator
        if (mnoise == '0) begin
          rem_r <= '0;
          q_r   <= KW'(1);
        end else begin
          rem_r <= {1'b0, p1_r};
          q_r   <= '0;
        end
      end
      S_DIV: begin
        rem_r <= ge ? diff[32:0] : shl[32:0];
        q_r   <= {q_r[KW-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
      end
      S_MULP: prod_r <= prod;
      S_MULE: prod_r <= prod;
      S_FIN:  est_r  <= est_sat;
      default: ;
    endcase
  end

  assign sts.idle = state_r == S_IDLE;
  assign sts.done = state_r == S_DONE;
  assign est      = est_r;
  assign variance = var_r;

endmodule

// ===== src/kalman_position_update_unit.sv =====
// Top level of the 3-axis Kalman position update unit: configuration
// registers, one kpu_lane per axis and the stage that merges lane results.
// Depends on kpu_pkg and kpu_lane.
//
// Usage:
//   in_valid/in_ready/in_data carry one item: command plus prior and
//   measured position per axis. out_valid/out_ready/out_data return one
//   result item per input item: estimate and variance per axis.
//   cfg_valid/cfg_ready/cfg_index/cfg_wdata write the noise and initial
//   variance registers; cfg_ready is always high. Write only while idle.
// Timing:
//   A filter update runs prepare, the bit-per-cycle gain divider, the
//   variance and estimate multiplies and a final step in each lane; the
//   lane results are then merged into the output register. No new item is
//   taken while the lanes are busy; the next one can be accepted in the cycle
//   after the result is merged. A reinitialize item goes straight to done.
//   All axes run in parallel on their own divider and multiplier.
// Reset and stall:
//   Reset restores register defaults and sets every variance to 0.0001.
//   A result waits in the output register while out_ready is low; lanes that
//   finish meanwhile hold theirs and in_ready stays low until it is taken.
module kalman_position_update_unit import kpu_pkg::*; #(
  parameter int VAR_FRAC_BITS = VAR_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  logic [31:0]        pnoise_r [AXES];
  logic [31:0]        mnoise_r [AXES];
  logic [31:0]        init_var_r;
  logic signed [31:0] prior_a  [AXES];
  logic signed [31:0] meas_a   [AXES];
  logic signed [31:0] est_a    [AXES];
  logic [31:0]        var_a    [AXES];
  lane_sts_t          sts      [AXES];
  logic [AXES-1:0]    idle_v;
  logic [AXES-1:0]    done_v;
  lane_ctl_t          ctl;
  logic               in_fire;
  logic               merge;
  logic               out_valid_r;
  out_item_t          out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        pnoise_r[i] <= RST_PNOISE;
        mnoise_r[i] <= RST_MNOISE;
      end
      init_var_r <= RST_INIT_VAR;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PNOISE_X: pnoise_r[0] <= cfg_wdata;
        REG_PNOISE_Y: pnoise_r[1] <= cfg_wdata;
        REG_PNOISE_Z: pnoise_r[2] <= cfg_wdata;
        REG_MNOISE_X: mnoise_r[0] <= cfg_wdata;
        REG_MNOISE_Y: mnoise_r[1] <= cfg_wdata;
        REG_MNOISE_Z: mnoise_r[2] <= cfg_wdata;
        REG_INIT_VAR: init_var_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign prior_a[0] = in_data.prior_x;
  assign prior_a[1] = in_data.prior_y;
  assign prior_a[2] = in_data.prior_z;
  assign meas_a[0]  = in_data.meas_x;
  assign meas_a[1]  = in_data.meas_y;
  assign meas_a[2]  = in_data.meas_z;

  assign in_ready   = &idle_v;
  assign in_fire    = in_valid && in_ready;
  assign merge      = (&done_v) && (!out_valid_r || out_ready);
  assign ctl.start  = in_fire;
  assign ctl.reinit = in_data.command == CMD_REINIT;
  assign ctl.take   = merge;

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    kpu_lane #(
      .VAR_FRAC_BITS(VAR_FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .pnoise   (pnoise_r[g]),
      .mnoise   (mnoise_r[g]),
      .init_var (init_var_r),
      .prior    (prior_a[g]),
      .meas     (meas_a[g]),
      .sts      (sts[g]),
      .est      (est_a[g]),
      .variance (var_a[g])
    );
    assign idle_v[g] = sts[g].idle;
    assign done_v[g] = sts[g].done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (merge) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (merge) begin
      out_data_r.est_x <= est_a[0];
      out_data_r.est_y <= est_a[1];
      out_data_r.est_z <= est_a[2];
      out_data_r.var_x <= var_a[0];
      out_data_r.var_y <= var_a[1];
      out_data_r.var_z <= var_a[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_reinit_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.command |=> &done_v)
    else $error("reinitialize item did not finish in one cycle");

  a_update_slow: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_data.command |=> done_v == '0)
    else $error("update item finished too early");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (done_v != '0) |-> &done_v)
    else $error("lanes out of step");

  a_merge_busy: assert property (@(posedge clk) disable iff (!rst_n)
    merge |-> !in_ready)
    else $error("merge while lanes idle");
`endif

endmodule

// ===== tb/kalman_position_update_unit_tb.sv =====
// Testbench for kalman_position_update_unit: random and directed position items,
// with each result checked against a per-axis estimate and variance scoreboard.
// Depends on kpu_pkg and the unit's RTL.
module kalman_position_update_unit_tb import kpu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     VAR_FRAC       = VAR_FRAC_BITS_DEF;
  localparam int     REG_COUNT      = int'(REG_INIT_VAR) + 1;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     WATCHDOG_LIMIT = 3000;
  localparam int     PHASES         = 7;
  localparam int     PHASE_ITEMS    = 150;
  localparam longint VAR_MAX        = 64'sh0000_0000_FFFF_FFFF;
  localparam longint S32_MAX        = 64'sd2147483647;
  localparam longint S32_MIN        = -64'sd2147483648;
  localparam longint ROUND_HALF     = 64'sd1 <<< (VAR_FRAC - 1);

  localparam logic                 CMD_UPDATE = ~CMD_REINIT;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;
  localparam logic signed [31:0]   POS_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]   POS_MIN    = 32'sh8000_0000;

  class kpu_scoreboard;
    logic [31:0] pnoise [AXES];
    logic [31:0] mnoise [AXES];
    logic [31:0] init_var;
    logic [31:0] lane_var [AXES];
    out_item_t   est_due [$];
    int          n_items, n_results, n_errors, n_reinit, n_zero_gain, n_var_sat;

    function new();
      for (int a = 0; a < AXES; a++) begin
        pnoise[a]   = RST_PNOISE;
        mnoise[a]   = RST_MNOISE;
        lane_var[a] = RST_INIT_VAR;
      end
      init_var = RST_INIT_VAR;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_PNOISE_X, REG_PNOISE_Y, REG_PNOISE_Z: pnoise[idx - REG_PNOISE_X] = val;
        REG_MNOISE_X, REG_MNOISE_Y, REG_MNOISE_Z: mnoise[idx - REG_MNOISE_X] = val;
        REG_INIT_VAR: init_var = val;
        default: ;
      endcase
    endfunction

    // one scalar lane: returns the estimate and advances the lane variance
    function logic signed [31:0] filter_axis(int a, bit reinit,
                                             logic signed [31:0] prior, logic signed [31:0] meas);
      longint p1, den, gain, innov, corr, shrink, est;
      if (reinit) begin
        lane_var[a] = init_var;
        return prior;
      end
      p1 = {32'd0, lane_var[a]} + {32'd0, pnoise[a]};
      if (p1 > VAR_MAX) begin
        p1 = VAR_MAX;
        n_var_sat++;
      end
      den  = p1 + {32'd0, mnoise[a]};
      gain = 0;
      if (den == 0) n_zero_gain++;
      else gain = (p1 << VAR_FRAC) / den;
      innov = longint'(meas) - longint'(prior);
      corr  = (gain * innov + ROUND_HALF) >>> VAR_FRAC;
      est   = longint'(prior) + corr;
      if (est > S32_MAX) est = S32_MAX;
      else if (est < S32_MIN) est = S32_MIN;
      shrink = (gain * p1 + ROUND_HALF) >>> VAR_FRAC;
      if (shrink < 0) shrink = 0;
      if (shrink > p1) shrink = p1;
      lane_var[a] = 32'(p1 - shrink);
      return 32'(est);
    endfunction

    function void note_item(in_item_t it);
      logic signed [31:0] pri [AXES];
      logic signed [31:0] mea [AXES];
      logic signed [31:0] est [AXES];
      out_item_t          want;
      pri = '{it.prior_x, it.prior_y, it.prior_z};
      mea = '{it.meas_x, it.meas_y, it.meas_z};
      n_items++;
      if (it.command == CMD_REINIT) n_reinit++;
      for (int a = 0; a < AXES; a++)
        est[a] = filter_axis(a, it.command == CMD_REINIT, pri[a], mea[a]);
      want.est_x = est[0];
      want.est_y = est[1];
      want.est_z = est[2];
      want.var_x = lane_var[0];
      want.var_y = lane_var[1];
      want.var_z = lane_var[2];
      est_due.push_back(want);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      n_results++;
      if (est_due.size() == 0) begin
        $error("result %h with no item outstanding", got);
        n_errors++;
        return;
      end
      want = est_due.pop_front();
      check_field("est_x", want.est_x, got.est_x);
      check_field("est_y", want.est_y, got.est_y);
      check_field("est_z", want.est_z, got.est_z);
      check_field("var_x", want.var_x, got.var_x);
      check_field("var_y", want.var_y, got.var_y);
      check_field("var_z", want.var_z, got.var_z);
    endfunction

    function int pending();
      return est_due.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;

  kpu_scoreboard scb;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int n_settings   = 0;
  int quiet_cycles = 0;
  int hold_left    = 0;
  bit hold_go      = 1'b0;
  bit hold_done    = 1'b0;

  kalman_position_update_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: check, random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) scb.check_result(out_data);
      if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("kalman_position_update_unit_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(7))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] meas_for(logic signed [31:0] prior);
    if ($urandom_range(3) == 0) return rand_pos();
    return prior + 32'(int'($urandom_range(0, 262144)) - 131072);
  endfunction

  function automatic in_item_t make_item(int reinit_pct);
    in_item_t it;
    it.command = ($urandom_range(99) < reinit_pct) ? CMD_REINIT : CMD_UPDATE;
    it.prior_x = rand_pos();
    it.prior_y = rand_pos();
    it.prior_z = rand_pos();
    it.meas_x  = meas_for(it.prior_x);
    it.meas_y  = meas_for(it.prior_y);
    it.meas_z  = meas_for(it.prior_z);
    return it;
  endfunction

  function automatic in_item_t uniform_item(logic cmd, logic signed [31:0] prior,
                                            logic signed [31:0] meas);
    return '{cmd, prior, prior, prior, meas, meas, meas};
  endfunction

  function automatic logic [31:0] pick_var();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 65535);
      3: return 32'h0100_0000 + $urandom_range(0, 4194304);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scb.note_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (scb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scb.write_reg(idx, val);
  endtask

  task automatic load_regs(input logic [31:0] vals [REG_COUNT]);
    for (int i = 0; i < REG_COUNT; i++) cfg_write(CFG_IDX_W'(i), vals[i]);
    cfg_write(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    scb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle_pct = 37;
    rcv_idle_pct = 49;

    // register defaults
    send_item(uniform_item(CMD_UPDATE, '0, '0));
    send_item(uniform_item(CMD_UPDATE, POS_MAX, POS_MIN));
    send_item(uniform_item(CMD_UPDATE, POS_MIN, POS_MAX));
    send_item(uniform_item(CMD_UPDATE, POS_MAX, POS_MAX));
    send_item(uniform_item(CMD_UPDATE, -32'sd1, 32'sd1));
    send_item(make_item(100));
    repeat (3) send_item(make_item(0));
    wait_idle();

    // zero variance and noise: zero denominator, gain of zero
    load_regs('{'0, '0, '0, '0, '0, '0, '0});
    send_item(make_item(100));
    send_item(uniform_item(CMD_UPDATE, POS_MIN, POS_MAX));
    send_item(make_item(0));
    wait_idle();

    // full-scale variance, no measurement noise: sum saturates, unit gain
    load_regs('{'1, '1, '1, '0, '0, '0, '1});
    send_item(make_item(100));
    send_item(uniform_item(CMD_UPDATE, POS_MAX, POS_MIN));
    send_item(make_item(0));
    wait_idle();

    // full-scale measurement noise
    load_regs('{$urandom, $urandom, $urandom, '1, '1, '1, $urandom});
    send_item(make_item(100));
    send_item(uniform_item(CMD_UPDATE, POS_MIN, POS_MAX));
    send_item(make_item(0));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      load_regs('{pick_var(), pick_var(), pick_var(), pick_var(), pick_var(), pick_var(),
                  pick_var()});
      if (ph < 3) begin
        snd_idle_pct = 37;
        rcv_idle_pct = 49;
      end else if (ph < 5) begin
        snd_idle_pct = 49;
        rcv_idle_pct = 37;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if (ph == 5) hold_go = 1'b1;
      repeat (PHASE_ITEMS) send_item(make_item(6));
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("checked %0d results for %0d items over %0d register settings",
             scb.n_results, scb.n_items, n_settings);
    $display("%0d reinitialize items, %0d zero-gain lane updates, %0d saturated variance sums",
             scb.n_reinit, scb.n_zero_gain, scb.n_var_sat);
    if (scb.n_errors == 0 && scb.pending() == 0)
      $display("kalman_position_update_unit_tb: done, clean");
    else
      $display("kalman_position_update_unit_tb: done, errors");
    $finish;
  end

endmodule

// ===== kalman_position_update_unit.f =====
src/kpu_pkg.sv
src/kpu_lane.sv
src/kalman_position_update_unit.sv
tb/kalman_position_update_unit_tb.sv
